// File: rtl/sensor_frame_crc_checker_top_defines.svh
// Assertion macros for the sensor frame CRC checker.
// Used by the port checker; expects clk and arst_n in scope.
`ifndef SENSOR_FRAME_CRC_CHECKER_TOP_DEFINES_SVH
`define SENSOR_FRAME_CRC_CHECKER_TOP_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define SFCC_ASSERT_NOW(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error(msg);

// Next-cycle implication, checked out of reset.
`define SFCC_ASSERT_NEXT(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error(msg);

`endif

// File: rtl/sfcc_pkg.sv
// Shared types, constants and the CRC-8 step function of the sensor frame checker.
// No dependencies.
package sfcc_pkg;

	// configuration register indexes
	localparam logic [1:0] CFG_POLY    = 2'd0;
	localparam logic [1:0] CFG_INIT    = 2'd1;
	localparam logic [1:0] CFG_CONVERT = 2'd2;

	localparam logic [7:0] POLY_RST    = 8'h31;
	localparam logic [7:0] INIT_RST    = 8'hFF;
	localparam logic       CONVERT_RST = 1'b1;

	// byte positions inside a frame
	localparam logic [2:0] POS_HI0  = 3'd0;
	localparam logic [2:0] POS_LO0  = 3'd1;
	localparam logic [2:0] POS_CRC0 = 3'd2;
	localparam logic [2:0] POS_HI1  = 3'd3;
	localparam logic [2:0] POS_LO1  = 3'd4;
	localparam logic [2:0] POS_CRC1 = 3'd5;

	// fixed-point conversion
	localparam int          CONV_SHIFT  = 13;
	localparam int          TEMP_PROD_W = 31;
	localparam int          HUM_PROD_W  = 30;
	localparam logic [14:0] TEMP_SCALE  = 15'd21875;
	localparam logic [13:0] HUM_SCALE   = 14'd12500;
	localparam logic [17:0] TEMP_OFFSET = 18'd45000;

	typedef struct packed {
		logic [7:0] crc_polynomial;
		logic [7:0] crc_initial;
		logic       convert_enable;
	} cfg_t;

	typedef struct packed {
		logic [15:0] first_word;
		logic [15:0] second_word;
		logic        convert_enable;
		logic        frame_status;
	} frm_t;

	// MSB-first CRC-8 over one byte
	function automatic logic [7:0] crc8_feed(input logic [7:0] crc_in,
	                                         input logic [7:0] data,
	                                         input logic [7:0] poly);
		logic [7:0] c;
		c = crc_in ^ data;
		for (int k = 0; k < 8; k++) begin
			c = c[7] ? ({c[6:0], 1'b0} ^ poly) : {c[6:0], 1'b0};
		end
		return c;
	endfunction

endpackage

// File: rtl/sfcc_frame.sv
// Byte position tracking, per-word CRC-8 check and frame assembly.
// Depends on sfcc_pkg.
module sfcc_frame (
	input  logic          clk,
	input  logic          arst_n,
	input  sfcc_pkg::cfg_t cfg,
	input  logic          in_valid,
	output logic          in_ready,
	input  logic [7:0]    rx_byte,
	input  logic          frame_start,
	output logic          frm_valid,
	input  logic          frm_ready,
	output sfcc_pkg::frm_t frm
);

	logic [2:0]     pos_q;
	logic [7:0]     crc_q;
	logic [7:0]     hi_q;
	logic [15:0]    first_q;
	logic [15:0]    second_q;
	logic           err_q;
	logic           frm_valid_s1;
	sfcc_pkg::frm_t frm_s1;

	logic [2:0]     pos_eff;
	logic [7:0]     crc_src;
	logic [7:0]     crc_next;
	logic           accept;
	logic           status_now;

	assign in_ready = !frm_valid_s1 || frm_ready;
	assign accept   = in_valid && in_ready;

	always_comb begin
		if (frame_start || pos_q > sfcc_pkg::POS_CRC1) begin
			pos_eff = sfcc_pkg::POS_HI0;
		end else begin
			pos_eff = pos_q;
		end
		// a high byte restarts the CRC from the configured seed
		crc_src = (pos_eff == sfcc_pkg::POS_HI0 || pos_eff == sfcc_pkg::POS_HI1) ?
		          cfg.crc_initial : crc_q;
		crc_next   = sfcc_pkg::crc8_feed(crc_src, rx_byte, cfg.crc_polynomial);
		status_now = err_q || (crc_q != rx_byte);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= sfcc_pkg::POS_HI0;
			crc_q    <= sfcc_pkg::INIT_RST;
			hi_q     <= '0;
			first_q  <= '0;
			second_q <= '0;
			err_q    <= 1'b0;
		end else if (accept) begin
			pos_q <= (pos_eff == sfcc_pkg::POS_CRC1) ? sfcc_pkg::POS_HI0 : pos_eff + 3'd1;
			case (pos_eff)
				sfcc_pkg::POS_HI0: begin
					err_q <= 1'b0;
					hi_q  <= rx_byte;
					crc_q <= crc_next;
				end
				sfcc_pkg::POS_HI1: begin
					hi_q  <= rx_byte;
					crc_q <= crc_next;
				end
				sfcc_pkg::POS_LO0: begin
					crc_q   <= crc_next;
					first_q <= {hi_q, rx_byte};
				end
				sfcc_pkg::POS_LO1: begin
					crc_q    <= crc_next;
					second_q <= {hi_q, rx_byte};
				end
				sfcc_pkg::POS_CRC0: begin
					if (crc_q != rx_byte) begin
						err_q <= 1'b1;
					end
				end
				default: begin
					err_q <= status_now;
				end
			endcase
		end
	end

	// frame register: loads on the last byte, holds while downstream stalls
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frm_valid_s1 <= 1'b0;
		end else if (accept && pos_eff == sfcc_pkg::POS_CRC1) begin
			frm_valid_s1 <= 1'b1;
		end else if (frm_ready) begin
			frm_valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && pos_eff == sfcc_pkg::POS_CRC1) begin
			frm_s1.first_word     <= first_q;
			frm_s1.second_word    <= second_q;
			frm_s1.convert_enable <= cfg.convert_enable;
			frm_s1.frame_status   <= status_now;
		end
	end

	assign frm_valid = frm_valid_s1;
	assign frm       = frm_s1;

endmodule

// File: rtl/sfcc_convert.sv
// Fixed-point conversion of a finished frame: multiply stage, then shift,
// offset and the output register. Depends on sfcc_pkg.
module sfcc_convert (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               frm_valid,
	output logic               frm_ready,
	input  sfcc_pkg::frm_t     frm,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [17:0] first_value,
	output logic [16:0]        second_value,
	output logic               frame_status
);

	logic                             valid_s2;
	logic [sfcc_pkg::TEMP_PROD_W-1:0] temp_prod_s2;
	logic [sfcc_pkg::HUM_PROD_W-1:0]  hum_prod_s2;
	logic [15:0]                      first_raw_s2;
	logic [15:0]                      second_raw_s2;
	logic                             convert_s2;
	logic                             status_s2;

	logic                             out_valid_q;
	logic [17:0]                      first_q;
	logic [16:0]                      second_q;
	logic                             status_q;

	logic                             out_load;
	logic                             s2_load;
	logic [17:0]                      first_next;
	logic [16:0]                      second_next;

	assign out_load  = !out_valid_q || out_ready;
	assign s2_load   = !valid_s2 || out_load;
	assign frm_ready = s2_load;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (s2_load) begin
			valid_s2 <= frm_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (s2_load && frm_valid) begin
			temp_prod_s2  <= sfcc_pkg::TEMP_PROD_W'(frm.first_word) *
			                 sfcc_pkg::TEMP_PROD_W'(sfcc_pkg::TEMP_SCALE);
			hum_prod_s2   <= sfcc_pkg::HUM_PROD_W'(frm.second_word) *
			                 sfcc_pkg::HUM_PROD_W'(sfcc_pkg::HUM_SCALE);
			first_raw_s2  <= frm.first_word;
			second_raw_s2 <= frm.second_word;
			convert_s2    <= frm.convert_enable;
			status_s2     <= frm.frame_status;
		end
	end

	always_comb begin
		if (convert_s2) begin
			// two's complement wrap in 18 bits gives the signed result
			first_next  = temp_prod_s2[sfcc_pkg::TEMP_PROD_W-1:sfcc_pkg::CONV_SHIFT] -
			              sfcc_pkg::TEMP_OFFSET;
			second_next = hum_prod_s2[sfcc_pkg::HUM_PROD_W-1:sfcc_pkg::CONV_SHIFT];
		end else begin
			first_next  = {2'b00, first_raw_s2};
			second_next = {1'b0, second_raw_s2};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load && valid_s2) begin
			first_q  <= first_next;
			second_q <= second_next;
			status_q <= status_s2;
		end
	end

	assign out_valid    = out_valid_q;
	assign first_value  = $signed(first_q);
	assign second_value = second_q;
	assign frame_status = status_q;

endmodule

// File: rtl/sensor_frame_crc_checker_top.sv
// Top level of the sensor frame CRC checker: configuration registers and
// the frame and conversion stages. Depends on sfcc_pkg, sfcc_frame, sfcc_convert.
//
//   channel | signals                                   | direction
//   in      | in_valid, in_ready, rx_byte, frame_start  | byte stream in
//   out     | out_valid, out_ready, first_value,        | one beat per frame
//           | second_value, frame_status                |
//   cfg     | cfg_valid, cfg_ready, cfg_index, cfg_data | register writes
//
// One byte is taken every cycle while in_ready is high; its CRC update is done
// in the cycle it arrives. After the sixth byte the result beat passes the frame
// register, multiply register and output register.
// Reset is asynchronous; it restores the register defaults and frame position 0.
// A stalled output backs up through the three registers; in_ready drops only when
// a finished frame is held in the frame register.
// cfg_ready is always high.
module sensor_frame_crc_checker_top (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [7:0]         rx_byte,
	input  logic               frame_start,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [17:0] first_value,
	output logic [16:0]        second_value,
	output logic               frame_status,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [1:0]         cfg_index,
	input  logic [7:0]         cfg_data
);

	sfcc_pkg::cfg_t cfg_q;
	sfcc_pkg::frm_t frm;
	logic           frm_valid;
	logic           frm_ready;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.crc_polynomial <= sfcc_pkg::POLY_RST;
			cfg_q.crc_initial    <= sfcc_pkg::INIT_RST;
			cfg_q.convert_enable <= sfcc_pkg::CONVERT_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				sfcc_pkg::CFG_POLY:    cfg_q.crc_polynomial <= cfg_data;
				sfcc_pkg::CFG_INIT:    cfg_q.crc_initial    <= cfg_data;
				sfcc_pkg::CFG_CONVERT: cfg_q.convert_enable <= cfg_data[0];
				default: begin
					// drop writes to unused indexes
				end
			endcase
		end
	end

	sfcc_frame u_frame (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.rx_byte     (rx_byte),
		.frame_start (frame_start),
		.frm_valid   (frm_valid),
		.frm_ready   (frm_ready),
		.frm         (frm)
	);

	sfcc_convert u_convert (
		.clk          (clk),
		.arst_n       (arst_n),
		.frm_valid    (frm_valid),
		.frm_ready    (frm_ready),
		.frm          (frm),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.first_value  (first_value),
		.second_value (second_value),
		.frame_status (frame_status)
	);

endmodule

// File: rtl/sfcc_checker.sv
// Port-level checker for the sensor frame CRC checker, bound to the top level.
// Depends on sensor_frame_crc_checker_top_defines.svh.
`include "sensor_frame_crc_checker_top_defines.svh"

module sfcc_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_ready,
	input logic [7:0]         rx_byte,
	input logic               frame_start,
	input logic               out_valid,
	input logic               out_ready,
	input logic signed [17:0] first_value,
	input logic [16:0]        second_value,
	input logic               frame_status,
	input logic               cfg_valid,
	input logic               cfg_ready,
	input logic [1:0]         cfg_index,
	input logic [7:0]         cfg_data
);

	// a stalled result beat holds its payload
	`SFCC_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
		out_valid && $stable(first_value) && $stable(second_value) && $stable(frame_status),
		"result beat changed while stalled")

	// register writes never stall
	`SFCC_ASSERT_NOW(a_cfg_ready, cfg_valid, cfg_ready, "cfg_ready low")

	// raw or converted, humidity stays within full scale
	`SFCC_ASSERT_NOW(a_hum_range, out_valid, second_value <= 17'd100000,
		"second_value above full scale")

	// raw or converted, temperature never drops below the offset
	`SFCC_ASSERT_NOW(a_temp_range, out_valid, first_value >= -18'sd45000,
		"first_value below offset")

endmodule

bind sensor_frame_crc_checker_top sfcc_checker u_sfcc_checker (.*);

// File: sim/testbench.sv
// Self-checking testbench for sensor_frame_crc_checker_top: byte stream in, one reading per frame.
// Predicts each frame result in SV, with its own CRC-8 and conversion, and checks every output beat.
// Depends on sfcc_pkg and the top-level RTL.
module testbench;

	localparam logic [1:0] CFG_SPARE = 2'd3;	// unmapped register index
	localparam int CLK_HALF = 4;
	localparam int RESET_CYCLES = 8;
	localparam int DRAIN_CYCLES = 10;
	localparam int CYCLE_LIMIT = 400000;

	typedef struct packed {
		logic [17:0] first_value;
		logic [16:0] second_value;
		logic        frame_status;
	} reading_t;

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_ready;
	logic [7:0]         rx_byte;
	logic               frame_start;
	logic               out_valid;
	logic               out_ready;
	logic signed [17:0] first_value;
	logic [16:0]        second_value;
	logic               frame_status;
	logic               cfg_valid;
	logic               cfg_ready;
	logic [1:0]         cfg_index;
	logic [7:0]         cfg_data;

	sensor_frame_crc_checker_top dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.rx_byte      (rx_byte),
		.frame_start  (frame_start),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.first_value  (first_value),
		.second_value (second_value),
		.frame_status (frame_status),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	// register shadow
	logic [7:0] poly_shadow;
	logic [7:0] init_shadow;
	logic       convert_shadow;

	// frame tracking state
	logic [2:0]  frame_pos;
	logic [7:0]  crc_acc;
	logic [7:0]  hi_byte;
	logic [15:0] word0;
	logic [15:0] word1;
	logic        crc_bad;

	reading_t expected_readings[$];

	int send_idle_pct;
	int stall_pct;
	int bytes_sent;
	int frames_checked;
	int crc_error_frames;
	int cfg_writes;
	int fail_count;
	int cycle_count;

	initial begin
		clk = 1'b0;
		forever #CLK_HALF clk = ~clk;
	end

	function automatic logic [7:0] crc8_step(input logic [7:0] acc, input logic [7:0] data,
	                                         input logic [7:0] poly);
		logic [7:0] r;
		logic       fb;
		r = acc ^ data;
		for (int i = 0; i < 8; i++) begin
			fb = r[7];
			r = {r[6:0], 1'b0};
			if (fb)
				r = r ^ poly;
		end
		return r;
	endfunction

	function automatic logic [15:0] rand_word();
		case ($urandom_range(7))
			0: return 16'h0000;
			1: return 16'hFFFF;
			default: return 16'($urandom);
		endcase
	endfunction

	task automatic reset_prediction();
		poly_shadow = sfcc_pkg::POLY_RST;
		init_shadow = sfcc_pkg::INIT_RST;
		convert_shadow = sfcc_pkg::CONVERT_RST;
		frame_pos = sfcc_pkg::POS_HI0;
		crc_acc = sfcc_pkg::INIT_RST;
		hi_byte = 8'h00;
		word0 = 16'h0000;
		word1 = 16'h0000;
		crc_bad = 1'b0;
	endtask

	// advance the frame tracker by one accepted byte
	task automatic predict_byte(input logic [7:0] b, input logic s);
		logic [2:0]  pos;
		logic        status;
		logic [31:0] gain;
		logic [31:0] offset;
		logic [31:0] scaled;
		logic [31:0] wide_word;
		reading_t    r;
		pos = s ? sfcc_pkg::POS_HI0 : frame_pos;
		if (pos > sfcc_pkg::POS_CRC1)
			pos = sfcc_pkg::POS_HI0;
		case (pos)
			sfcc_pkg::POS_HI0, sfcc_pkg::POS_HI1: begin
				if (pos == sfcc_pkg::POS_HI0)
					crc_bad = 1'b0;
				hi_byte = b;
				crc_acc = crc8_step(init_shadow, b, poly_shadow);
			end
			sfcc_pkg::POS_LO0, sfcc_pkg::POS_LO1: begin
				crc_acc = crc8_step(crc_acc, b, poly_shadow);
				if (pos == sfcc_pkg::POS_LO0)
					word0 = {hi_byte, b};
				else
					word1 = {hi_byte, b};
			end
			sfcc_pkg::POS_CRC0: begin
				if (crc_acc != b)
					crc_bad = 1'b1;
			end
			default: begin
				status = crc_bad | (crc_acc != b);
				if (convert_shadow) begin
					gain = 32'(sfcc_pkg::TEMP_SCALE);
					offset = 32'(sfcc_pkg::TEMP_OFFSET);
					wide_word = 32'(word0);
					scaled = (gain * wide_word) >> sfcc_pkg::CONV_SHIFT;
					scaled = scaled - offset;
					r.first_value = scaled[17:0];
					gain = 32'(sfcc_pkg::HUM_SCALE);
					wide_word = 32'(word1);
					scaled = (gain * wide_word) >> sfcc_pkg::CONV_SHIFT;
					r.second_value = scaled[16:0];
				end else begin
					r.first_value = {2'b00, word0};
					r.second_value = {1'b0, word1};
				end
				r.frame_status = status;
				crc_bad = status;
				expected_readings.push_back(r);
			end
		endcase
		frame_pos = (pos >= sfcc_pkg::POS_CRC1) ? sfcc_pkg::POS_HI0 : pos + 3'd1;
	endtask

	// send one byte beat; valid stays up until accepted
	task automatic send_byte(input logic [7:0] b, input logic s);
		while ($urandom_range(99) < send_idle_pct) begin
			@(negedge clk);
			in_valid <= 1'b0;
		end
		@(negedge clk);
		in_valid <= 1'b1;
		rx_byte <= b;
		frame_start <= s;
		do @(posedge clk); while (!in_ready);
		predict_byte(b, s);
		bytes_sent++;
	endtask

	task automatic send_frame(input logic [15:0] w0, input logic [15:0] w1,
	                          input logic bad0, input logic bad1, input logic s);
		logic [7:0] c0;
		logic [7:0] c1;
		c0 = crc8_step(crc8_step(init_shadow, w0[15:8], poly_shadow), w0[7:0], poly_shadow);
		c1 = crc8_step(crc8_step(init_shadow, w1[15:8], poly_shadow), w1[7:0], poly_shadow);
		if (bad0)
			c0 = c0 ^ 8'($urandom_range(255, 1));
		if (bad1)
			c1 = c1 ^ 8'($urandom_range(255, 1));
		send_byte(w0[15:8], s);
		send_byte(w0[7:0], 1'b0);
		send_byte(c0, 1'b0);
		send_byte(w1[15:8], 1'b0);
		send_byte(w1[7:0], 1'b0);
		send_byte(c1, 1'b0);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [7:0] data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			sfcc_pkg::CFG_POLY: poly_shadow = data;
			sfcc_pkg::CFG_INIT: init_shadow = data;
			sfcc_pkg::CFG_CONVERT: convert_shadow = data[0];
			default: ;
		endcase
		cfg_writes++;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// drop valid, wait for all readings, then let the pipeline empty
	task automatic settle();
		@(negedge clk);
		in_valid <= 1'b0;
		while (expected_readings.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic set_idling(input int send_pct, input int recv_pct);
		send_idle_pct = send_pct;
		stall_pct = recv_pct;
	endtask

	// mostly well-formed frames, plus bad CRCs, cut-off frames and noise
	task automatic run_stream(input int n_bytes);
		int start_count;
		int kind;
		int n;
		logic s;
		start_count = bytes_sent;
		while (bytes_sent - start_count < n_bytes) begin
			kind = $urandom_range(99);
			s = (frame_pos == sfcc_pkg::POS_HI0) ? 1'($urandom_range(1)) : 1'b1;
			if (kind < 70) begin
				send_frame(rand_word(), rand_word(), 1'b0, 1'b0, s);
			end else if (kind < 82) begin
				send_frame(rand_word(), rand_word(), 1'($urandom_range(1)),
				           1'($urandom_range(1)), s);
			end else if (kind < 92) begin
				n = $urandom_range(5, 1);
				send_byte(8'($urandom), 1'b1);
				for (int i = 1; i < n; i++)
					send_byte(8'($urandom), 1'b0);
			end else begin
				n = $urandom_range(4, 1);
				for (int i = 0; i < n; i++)
					send_byte(8'($urandom), 1'($urandom_range(1)));
			end
		end
	endtask

	// extremes, CRC failures, missing start flag and a restart mid-frame
	task automatic test_directed_frames();
		set_idling(0, 0);
		send_frame(16'h0000, 16'h0000, 1'b0, 1'b0, 1'b1);
		send_frame(16'hFFFF, 16'hFFFF, 1'b1, 1'b0, 1'b0);
		send_byte(8'hA5, 1'b1);
		send_byte(8'h5A, 1'b0);
		send_frame(16'h8000, 16'h7FFF, 1'b0, 1'b1, 1'b1);
		settle();
	endtask

	task automatic test_default_stream();
		set_idling(0, 0);
		run_stream(300);
		settle();
	endtask

	task automatic test_alt_polynomial();
		write_reg(sfcc_pkg::CFG_POLY, 8'h07);
		write_reg(sfcc_pkg::CFG_INIT, 8'h00);
		write_reg(sfcc_pkg::CFG_CONVERT, 8'h01);
		set_idling(83, 0);
		run_stream(320);
		settle();
	endtask

	task automatic test_raw_words();
		set_idling(0, 0);
		write_reg(sfcc_pkg::CFG_POLY, 8'hFF);
		write_reg(sfcc_pkg::CFG_INIT, 8'hFF);
		write_reg(sfcc_pkg::CFG_CONVERT, 8'hFE);	// only bit 0 counts
		set_idling(0, 83);
		run_stream(320);
		settle();
	endtask

	task automatic test_zero_polynomial();
		set_idling(0, 0);
		write_reg(sfcc_pkg::CFG_POLY, 8'h00);
		write_reg(sfcc_pkg::CFG_INIT, 8'h00);
		write_reg(sfcc_pkg::CFG_CONVERT, 8'h01);
		write_reg(CFG_SPARE, 8'($urandom));
		set_idling(6, 6);
		run_stream(320);
		settle();
	endtask

	task automatic test_random_settings();
		for (int round = 0; round < 3; round++) begin
			set_idling(0, 0);
			write_reg(sfcc_pkg::CFG_POLY, 8'($urandom));
			write_reg(sfcc_pkg::CFG_INIT, 8'($urandom));
			write_reg(sfcc_pkg::CFG_CONVERT, 8'($urandom));
			case ($urandom_range(3))
				0: set_idling(0, 0);
				1: set_idling(83, 0);
				2: set_idling(0, 83);
				default: set_idling(6, 6);
			endcase
			run_stream(120);
			settle();
		end
	endtask

	always @(negedge clk)
		out_ready <= ($urandom_range(99) >= stall_pct);

	// check each output beat against the oldest predicted reading
	always @(posedge clk) begin
		reading_t want;
		if (arst_n && out_valid && out_ready) begin
			if (expected_readings.size() == 0) begin
				$error("unexpected reading: first_value %0d second_value %0d frame_status %0d",
				       first_value, second_value, frame_status);
				fail_count++;
			end else begin
				want = expected_readings.pop_front();
				frames_checked++;
				if (want.frame_status)
					crc_error_frames++;
				if (first_value !== want.first_value) begin
					$error("first_value: expected %0d, got %0d",
					       $signed(want.first_value), first_value);
					fail_count++;
				end
				if (second_value !== want.second_value) begin
					$error("second_value: expected %0d, got %0d", want.second_value,
					       second_value);
					fail_count++;
				end
				if (frame_status !== want.frame_status) begin
					$error("frame_status: expected %0d, got %0d", want.frame_status,
					       frame_status);
					fail_count++;
				end
			end
		end
	end

	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("timeout after %0d cycles", cycle_count);
		$display("sensor_frame_crc_checker_top: mismatch");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		rx_byte = 8'h00;
		frame_start = 1'b0;
		out_ready = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = sfcc_pkg::CFG_POLY;
		cfg_data = 8'h00;
		send_idle_pct = 0;
		stall_pct = 0;
		bytes_sent = 0;
		frames_checked = 0;
		crc_error_frames = 0;
		cfg_writes = 0;
		fail_count = 0;
		reset_prediction();
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_directed_frames();
		test_default_stream();
		test_alt_polynomial();
		test_raw_words();
		test_zero_polynomial();
		test_random_settings();

		$display("covered %0d bytes and %0d register writes across polynomial, init and",
		         bytes_sent, cfg_writes);
		$display("conversion settings; %0d readings checked, %0d with CRC errors",
		         frames_checked, crc_error_frames);
		if (fail_count == 0) begin
			$display("sensor_frame_crc_checker_top: match");
		end else begin
			$display("sensor_frame_crc_checker_top: mismatch");
		end
		$finish;
	end

endmodule
